>>> hdl/ofs_pkg.sv
// Shared types and constants for the open-loop FOC space-vector modulator.
// Used by ofs_mul, ofs_div and openloop_foc_svpwm_top; no dependencies.
package ofs_pkg;

  localparam int ANGLE_W    = 16;  // phase accumulator width, one turn = 2^ANGLE_W
  localparam int SINE_IDX_W = 8;   // log2 of the sine table depth (256 steps per turn)
  localparam int VOLT_W     = 16;  // width kept by the voltage registers
  localparam int PH_W       = 52;  // phase voltages in mV * 2^30, signed
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 18;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_STEPS  = 8;   // two quotient bits per step, 16 bits in all

  // sine polynomial coefficients (Q14) and sqrt(3)/2 in Q16
  localparam logic [14:0] SIN_A       = 15'd25736;
  localparam logic [14:0] SIN_B       = 15'd10512;
  localparam logic [17:0] SIN_C       = 18'd1160;
  localparam logic [14:0] Q14_ONE     = 15'd16384;
  localparam logic [15:0] QUARTER     = 16'h4000;
  localparam logic [17:0] SQRT3_2_Q16 = 18'd56756;

  // register reset values
  localparam logic [VOLT_W-1:0]  BUS_RST   = 16'd12000;
  localparam logic [VOLT_W-1:0]  LIMIT_RST = 16'd11400;
  localparam logic [VOLT_W-1:0]  VQ_RST    = 16'd1000;
  localparam logic [ANGLE_W-1:0] STEP_RST  = 16'd328;

  typedef enum logic [7:0] {
    CFG_BUS      = 8'd0,
    CFG_LIMIT    = 8'd1,
    CFG_SETPOINT = 8'd2,
    CFG_STEP     = 8'd3
  } cfg_idx_e;

  // divider request from the sequencer
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } ofs_div_req_t;

endpackage

>>> hdl/openloop_foc_svpwm_top.sv
// Open-loop FOC voltage modulator with min-max space-vector PWM.
// The block works on one input item at a time: s_axis_tready stays low until the result is registered.
// The sequencer walks the shared multiplier (sine, cosine, Park/Clarke products) and
// runs the two-bit-per-cycle divider once per phase.
// Reset (rst_ni low, asynchronous): registers to defaults, accumulator to zero, output empty.
// Depends on ofs_pkg, ofs_mul and ofs_div.
module openloop_foc_svpwm_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] period_count
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] compare_a, [31:16] compare_b,
                                      // [47:32] compare_c, [63:48] electrical_angle
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int PW = ofs_pkg::PH_W;

  // One-hot sequencer states
  typedef enum logic [18:0] {
    ST_IDLE  = 19'b1 << 0,
    ST_TZ    = 19'b1 << 1,   // fold angle into quadrant
    ST_TSQ   = 19'b1 << 2,   // z*z
    ST_TC    = 19'b1 << 3,   // z2*C
    ST_TR1   = 19'b1 << 4,   // z2*(B - ...)
    ST_TR2   = 19'b1 << 5,   // z*(A - ...)
    ST_TS    = 19'b1 << 6,   // take sine or cosine
    ST_PA    = 19'b1 << 7,   // sin*Vq
    ST_PB    = 19'b1 << 8,   // cos*Vq
    ST_PC    = 19'b1 << 9,   // sqrt(3)/2 * ubeta
    ST_PD    = 19'b1 << 10,  // form three phases
    ST_MM1   = 19'b1 << 11,
    ST_MM2   = 19'b1 << 12,
    ST_SUM   = 19'b1 << 13,
    ST_V2    = 19'b1 << 14,  // add centering and mid-rail offset
    ST_CLMP  = 19'b1 << 15,
    ST_VMUL  = 19'b1 << 16,  // v*period
    ST_DWAIT = 19'b1 << 17,  // divide by bus voltage
    ST_OUT   = 19'b1 << 18
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] bus_q, limit_q, vq_q, step_q;

  // datapath registers
  logic [ofs_pkg::ANGLE_W-1:0] acc_q, acc_d;
  logic [15:0]                 period_q, period_d;
  logic                        cos_q, cos_d;
  logic [14:0]                 z_q, z_d, z2_q, z2_d;
  logic                        neg_q, neg_d;
  logic signed [15:0]          sn_q, sn_d, cs_q, cs_d;
  logic signed [31:0]          ualpha_q, ualpha_d;
  logic signed [PW-1:0]        ua_q, ua_d, ub_q, ub_d, uc_q, uc_d;
  logic signed [PW-1:0]        mx_q, mx_d, mn_q, mn_d, sum_q, sum_d, v2_q, v2_d;
  logic [31:0]                 v_q, v_d;
  logic                        full_q, full_d, zero_q, zero_d;
  logic [1:0]                  ph_q, ph_d;
  logic [15:0]                 cmp_q [3];
  logic [15:0]                 cmp_d;
  logic                        cmp_we;
  logic                        m_valid_q, m_valid_d;
  logic [63:0]                 m_data_q, m_data_d;
  logic                        div_go_q;

  // shared units
  logic signed [ofs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ofs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ofs_pkg::MUL_P_W-1:0] mul_p;
  ofs_pkg::ofs_div_req_t              div_req;
  logic                               div_done;
  logic [15:0]                        div_quo;

  ofs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ofs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // combinational helpers
  logic [15:0]          turn;
  logic [14:0]          zf, prod_hi;
  logic [15:0]          uq;
  logic signed [15:0]   sv;
  logic signed [PW-1:0] mterm, halfa, u_sel, hi_lim, bus_off;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // configuration writes, any index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q   <= ofs_pkg::BUS_RST;
      limit_q <= ofs_pkg::LIMIT_RST;
      vq_q    <= ofs_pkg::VQ_RST;
      step_q  <= ofs_pkg::STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ofs_pkg::CFG_BUS:      bus_q   <= cfg_data_i;
        ofs_pkg::CFG_LIMIT:    limit_q <= cfg_data_i;
        ofs_pkg::CFG_SETPOINT: vq_q    <= cfg_data_i;
        ofs_pkg::CFG_STEP:     step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // quantize angle to table steps, then shift to a quarter for cosine
    turn = {acc_q[ofs_pkg::ANGLE_W-1 -: ofs_pkg::SINE_IDX_W],
            {(16 - ofs_pkg::SINE_IDX_W){1'b0}}} + (cos_q ? ofs_pkg::QUARTER : 16'h0000);
    zf      = turn[14] ? (ofs_pkg::Q14_ONE - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
    prod_hi = mul_p[28:14];
    sv      = neg_q ? -$signed({1'b0, prod_hi}) : $signed({1'b0, prod_hi});
    uq      = (vq_q < limit_q) ? vq_q : limit_q;
    mterm   = {mul_p[ofs_pkg::MUL_P_W-1], mul_p};
    halfa   = {{5{ualpha_q[31]}}, ualpha_q, 15'b0};
    hi_lim  = $signed({5'b0, limit_q, 31'b0});
    bus_off = $signed({6'b0, bus_q, 30'b0});
    case (ph_q)
      2'd0:    u_sel = ua_q;
      2'd1:    u_sel = ub_q;
      default: u_sel = uc_q;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_TSQ: begin
        mul_a = {18'b0, z_q};
        mul_b = {3'b0, z_q};
      end
      ST_TC: begin
        mul_a = {18'b0, prod_hi};
        mul_b = ofs_pkg::SIN_C;
      end
      ST_TR1: begin
        mul_a = {18'b0, z2_q};
        mul_b = {3'b0, ofs_pkg::SIN_B - prod_hi};
      end
      ST_TR2: begin
        mul_a = {18'b0, z_q};
        mul_b = {3'b0, ofs_pkg::SIN_A - prod_hi};
      end
      ST_PA: begin
        mul_a = {{17{sn_q[15]}}, sn_q};
        mul_b = {2'b0, uq};
      end
      ST_PB: begin
        mul_a = {{17{cs_q[15]}}, cs_q};
        mul_b = {2'b0, uq};
      end
      ST_PC: begin
        mul_a = {mul_p[31], mul_p[31:0]};
        mul_b = ofs_pkg::SQRT3_2_Q16;
      end
      ST_VMUL: begin
        mul_a = {1'b0, v_q};
        mul_b = {2'b0, period_q};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    period_d  = period_q;
    cos_d     = cos_q;
    z_d       = z_q;
    z2_d      = z2_q;
    neg_d     = neg_q;
    sn_d      = sn_q;
    cs_d      = cs_q;
    ualpha_d  = ualpha_q;
    ua_d      = ua_q;
    ub_d      = ub_q;
    uc_d      = uc_q;
    mx_d      = mx_q;
    mn_d      = mn_q;
    sum_d     = sum_q;
    v2_d      = v2_q;
    v_d       = v_q;
    full_d    = full_q;
    zero_d    = zero_q;
    ph_d      = ph_q;
    cmp_d     = div_quo;
    cmp_we    = 1'b0;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    div_req   = '{start: div_go_q, num: mul_p[47:16], den: bus_q};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          acc_d    = acc_q + step_q;
          period_d = s_axis_tdata;
          cos_d    = 1'b0;
          state_d  = ST_TZ;
        end
      end
      ST_TZ: begin
        z_d     = zf;
        neg_d   = turn[15];
        state_d = ST_TSQ;
      end
      ST_TSQ: state_d = ST_TC;
      ST_TC: begin
        z2_d    = prod_hi;
        state_d = ST_TR1;
      end
      ST_TR1: state_d = ST_TR2;
      ST_TR2: state_d = ST_TS;
      ST_TS: begin
        if (!cos_q) begin
          sn_d    = sv;
          cos_d   = 1'b1;
          state_d = ST_TZ;
        end else begin
          cs_d    = sv;
          state_d = ST_PA;
        end
      end
      ST_PA: state_d = ST_PB;
      ST_PB: begin
        // ualpha = -sin * Vq
        ualpha_d = -mul_p[31:0];
        state_d  = ST_PC;
      end
      ST_PC: state_d = ST_PD;
      ST_PD: begin
        ua_d    = {{4{ualpha_q[31]}}, ualpha_q, 16'b0};
        ub_d    = mterm - halfa;
        uc_d    = -(halfa + mterm);
        state_d = ST_MM1;
      end
      ST_MM1: begin
        mx_d    = (ua_q > ub_q) ? ua_q : ub_q;
        mn_d    = (ua_q < ub_q) ? ua_q : ub_q;
        state_d = ST_MM2;
      end
      ST_MM2: begin
        mx_d    = (mx_q > uc_q) ? mx_q : uc_q;
        mn_d    = (mn_q < uc_q) ? mn_q : uc_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sum_d   = mx_q + mn_q;
        ph_d    = 2'd0;
        state_d = ST_V2;
      end
      ST_V2: begin
        // doubled phase, minus min+max, plus half bus, in mV * 2^31
        v2_d    = (u_sel <<< 1) - sum_q + bus_off;
        state_d = ST_CLMP;
      end
      ST_CLMP: begin
        if (v2_q[PW-1]) begin
          v_d = '0;
        end else if (v2_q > hi_lim) begin
          v_d = hi_lim[46:15];
        end else begin
          v_d = v2_q[46:15];
        end
        state_d = ST_VMUL;
      end
      ST_VMUL: begin
        full_d  = v_q >= {bus_q, 16'b0};
        zero_d  = (bus_q == 16'd0) || (period_q == 16'd0);
        state_d = ST_DWAIT;
        // product lands next cycle: launch the divider from there
      end
      ST_DWAIT: begin
        if (div_done) begin
          cmp_we = 1'b1;
          if (zero_q) begin
            cmp_d = '0;
          end else if (full_q) begin
            cmp_d = period_q;
          end else begin
            cmp_d = div_quo;
          end
          if (ph_q == 2'd2) begin
            state_d = ST_OUT;
          end else begin
            ph_d    = ph_q + 2'd1;
            state_d = ST_V2;
          end
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = {acc_q[15:0], cmp_q[2], cmp_q[1], cmp_q[0]};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // launch the divider the cycle the v*period product is valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= (state_q == ST_VMUL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      cos_q     <= 1'b0;
      ph_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      cos_q     <= cos_d;
      ph_q      <= ph_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    z_q      <= z_d;
    z2_q     <= z2_d;
    neg_q    <= neg_d;
    sn_q     <= sn_d;
    cs_q     <= cs_d;
    ualpha_q <= ualpha_d;
    ua_q     <= ua_d;
    ub_q     <= ub_d;
    uc_q     <= uc_d;
    mx_q     <= mx_d;
    mn_q     <= mn_d;
    sum_q    <= sum_d;
    v2_q     <= v2_d;
    v_q      <= v_d;
    full_q   <= full_d;
    zero_q   <= zero_d;
    m_data_q <= m_data_d;
    if (cmp_we) begin
      cmp_q[ph_q] <= cmp_d;
    end
  end

endmodule

>>> hdl/ofs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ofs_pkg for operand widths.
module ofs_mul (
  input  logic                                clk_i,
  input  logic signed [ofs_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [ofs_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [ofs_pkg::MUL_P_W-1:0]  p_o
);

  logic signed [ofs_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> hdl/ofs_div.sv
// Iterative restoring divider, 32-bit dividend by 16-bit divisor, two bits a cycle.
// Depends on ofs_pkg for the request struct and step count; quotient valid when done_o pulses.
module ofs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ofs_pkg::ofs_div_req_t req_i,
  output logic                  done_o,
  output logic [15:0]           quo_o
);

  logic [15:0] rem_q, rem_d;
  logic [15:0] low_q, low_d;
  logic [15:0] den_q, den_d;
  logic [15:0] quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  logic [16:0] t1, t2, s1, s2;
  logic        ge1, ge2;
  logic [15:0] r1;

  always_comb begin
    t1  = {rem_q, low_q[15]};
    ge1 = t1 >= {1'b0, den_q};
    s1  = t1 - {1'b0, den_q};
    r1  = ge1 ? s1[15:0] : t1[15:0];
    t2  = {r1, low_q[14]};
    ge2 = t2 >= {1'b0, den_q};
    s2  = t2 - {1'b0, den_q};

    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num[31:16];
      low_d  = req_i.num[15:0];
      den_d  = req_i.den;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge2 ? s2[15:0] : t2[15:0];
      low_d = {low_q[13:0], 2'b00};
      quo_d = {quo_q[13:0], ge1, ge2};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'(ofs_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> hdl/ofs_chk.sv
// Port-level checker for openloop_foc_svpwm_top, attached by the bind below.
// Depends on the top level's port names only.
module ofs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // the block works on one item at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

  // a new result never appears in the cycle after an input transfer
  a_result_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too early");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind openloop_foc_svpwm_top ofs_chk u_ofs_chk (.*);
